>>> src/sscacc_pkg.sv
package sscacc_pkg;

  localparam int unsigned SqrtSteps = 33;
  localparam int unsigned DivSteps  = 62;
  localparam int unsigned SqrtCntW  = $clog2(SqrtSteps + 1);
  localparam int unsigned DivCntW   = $clog2(DivSteps + 1);
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  // 2.0 in Q16.16
  localparam logic [61:0] OverlapOffset = 62'd131072;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [30:0] radius;
    logic [30:0] rest;
    logic        last;
    logic        has_seg;
  } item_t;

  typedef enum logic [4:0] {
    B_IDLE,
    B_SQ,
    B_SQRTGO,
    B_SQRTW,
    B_RR,
    B_DIVGO,
    B_DIVW,
    B_OV,
    B_OVSQ,
    B_E,
    B_K1,
    B_K2,
    B_K3,
    B_K4,
    B_ACC,
    B_UPD,
    B_EMIT
  } bstate_e;

endpackage

>>> src/sscacc_front.sv
module sscacc_front import sscacc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] point_x_i,
  input  logic [31:0] point_y_i,
  input  logic [31:0] point_z_i,
  input  logic [30:0] point_radius_i,
  input  logic [30:0] rest_length_i,
  input  logic        last_point_i,
  output logic        q_valid_o,
  output item_t       q_item_o,
  input  logic        q_pop_i
);

  item_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0]  wptr_q, rptr_q;
  logic [QueuePtrW:0]    cnt_q;
  logic                  have_prev_q;
  logic                  push;
  item_t                 entry;

  assign in_stall_o = (cnt_q == (QueuePtrW + 1)'(QueueDepth));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = mem_q[rptr_q];

  always_comb begin
    entry.x       = point_x_i;
    entry.y       = point_y_i;
    entry.z       = point_z_i;
    entry.radius  = (point_radius_i == '0) ? 31'd1 : point_radius_i;
    entry.rest    = rest_length_i;
    entry.last    = last_point_i;
    entry.has_seg = have_prev_q;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q      <= '0;
      rptr_q      <= '0;
      cnt_q       <= '0;
      have_prev_q <= 1'b0;
    end else begin
      if (push) begin
        wptr_q      <= wptr_q + 1'b1;
        have_prev_q <= !last_point_i;
      end
      if (q_pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push && !q_pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push && q_pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> src/sscacc_sqrt.sv
module sscacc_sqrt import sscacc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [65:0] radicand_i,
  output logic        done_o,
  output logic [32:0] root_o
);

  logic [65:0]         rad_q;
  logic [35:0]         rem_q;
  logic [32:0]         root_q;
  logic [SqrtCntW-1:0] cnt_q;
  logic                busy_q, done_q;
  logic [37:0]         rem_s, trial;

  assign rem_s  = {rem_q, rad_q[65:64]};
  assign trial  = {3'b0, root_q, 2'b01};
  assign done_o = done_q;
  assign root_o = root_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= {rad_q[63:0], 2'b00};
      if (rem_s >= trial) begin
        rem_q  <= 36'(rem_s - trial);
        root_q <= {root_q[31:0], 1'b1};
      end else begin
        rem_q  <= rem_s[35:0];
        root_q <= {root_q[31:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == SqrtCntW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= SqrtCntW'(SqrtSteps);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == SqrtCntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

endmodule

>>> src/sscacc_div.sv
module sscacc_div import sscacc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [61:0] num_i,
  input  logic [32:0] den_i,
  output logic        done_o,
  output logic [61:0] quot_o
);

  logic [61:0]        num_q;
  logic [32:0]        den_q, rem_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q, done_q;
  logic [33:0]        rem_s;

  assign rem_s  = {rem_q, num_q[61]};
  assign done_o = done_q;
  assign quot_o = num_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      if (rem_s >= {1'b0, den_q}) begin
        rem_q <= 33'(rem_s - {1'b0, den_q});
        num_q <= {num_q[60:0], 1'b1};
      end else begin
        rem_q <= rem_s[32:0];
        num_q <= {num_q[60:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == DivCntW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DivCntW'(DivSteps);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DivCntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

endmodule

>>> src/sscacc_back.sv
module sscacc_back import sscacc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        mode_i,
  input  logic        q_valid_i,
  input  item_t       q_item_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] strand_cost_o,
  output logic [15:0] segment_count_o,
  output logic        cost_saturated_o
);

  bstate_e state_q, state_d;

  item_t        cur_q;
  logic [31:0]  px_q, py_q, pz_q;
  logic [30:0]  pr_q;
  logic [65:0]  sumsq_q;
  logic [32:0]  d_q;
  logic [61:0]  quot_q;
  logic [63:0]  seg_q;
  logic         seg_sat_q;
  logic [65:0]  ee_q;
  logic [34:0]  k_q;
  logic [67:0]  big_q;
  logic [63:0]  sum_q;
  logic [15:0]  cnt_q;
  logic         sat_q;
  logic [1:0]   sq_q;
  logic [69:0]  prod_q;
  logic         ovalid_q;
  logic [63:0]  ocost_q;
  logic [15:0]  ocnt_q;
  logic         osat_q;

  logic [34:0]  mul_a, mul_b;
  logic         sqrt_start, sqrt_done, div_start, div_done;
  logic [32:0]  root, rsum, ax, ay, az;
  logic [61:0]  quot, div_num, qv;
  logic [32:0]  e_val;
  logic [100:0] total;
  logic [64:0]  s_sum;
  logic         emit_fire;

  function automatic logic [32:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
    logic signed [32:0] t;
    t = $signed({a[31], a}) - $signed({b[31], b});
    return t[32] ? 33'(-t) : 33'(t);
  endfunction

  assign ax    = abs_diff(cur_q.x, px_q);
  assign ay    = abs_diff(cur_q.y, py_q);
  assign az    = abs_diff(cur_q.z, pz_q);
  assign rsum  = {2'b0, pr_q} + {2'b0, cur_q.radius};
  assign qv    = (quot_q > OverlapOffset) ? (quot_q - OverlapOffset) : '0;
  assign e_val = (d_q > {2'b0, cur_q.rest}) ? (d_q - {2'b0, cur_q.rest}) : '0;
  assign total = {33'b0, big_q} + {prod_q[67:0], 33'b0};
  assign s_sum = {1'b0, sum_q} + {1'b0, seg_q};
  assign div_num = mode_i ? prod_q[61:0] : {13'b0, d_q, 16'b0};
  assign emit_fire = (state_q == B_EMIT) && (!ovalid_q || !out_stall_i);

  sscacc_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (sumsq_q),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  sscacc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (rsum),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE:   if (q_valid_i) state_d = q_item_i.has_seg ? B_SQ : B_UPD;
      B_SQ:     if (sq_q == 2'd3) state_d = B_SQRTGO;
      B_SQRTGO: state_d = B_SQRTW;
      B_SQRTW:  if (sqrt_done) state_d = mode_i ? B_RR : B_DIVGO;
      B_RR:     state_d = B_DIVGO;
      B_DIVGO:  state_d = B_DIVW;
      B_DIVW:   if (div_done) state_d = mode_i ? B_E : B_OV;
      B_OV:     state_d = (qv[61:32] != '0) ? B_ACC : B_OVSQ;
      B_OVSQ:   state_d = B_ACC;
      B_E:      state_d = B_K1;
      B_K1:     state_d = B_K2;
      B_K2:     state_d = B_K3;
      B_K3:     state_d = B_K4;
      B_K4:     state_d = B_ACC;
      B_ACC:    state_d = B_UPD;
      B_UPD:    state_d = cur_q.last ? B_EMIT : B_IDLE;
      B_EMIT:   if (emit_fire) state_d = B_IDLE;
      default:  state_d = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o    = 1'b0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state_q)
      B_IDLE:   q_pop_o = q_valid_i;
      B_SQ: begin
        case (sq_q)
          2'd0:    begin mul_a = {2'b0, ax}; mul_b = {2'b0, ax}; end
          2'd1:    begin mul_a = {2'b0, ay}; mul_b = {2'b0, ay}; end
          2'd2:    begin mul_a = {2'b0, az}; mul_b = {2'b0, az}; end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      B_SQRTGO: sqrt_start = 1'b1;
      B_RR:     begin mul_a = {4'b0, pr_q}; mul_b = {4'b0, cur_q.radius}; end
      B_DIVGO:  div_start = 1'b1;
      B_OV:     begin mul_a = {3'b0, qv[31:0]}; mul_b = {3'b0, qv[31:0]}; end
      B_E:      begin mul_a = {2'b0, e_val}; mul_b = {2'b0, e_val}; end
      B_K2:     begin mul_a = k_q; mul_b = {2'b0, ee_q[32:0]}; end
      B_K3:     begin mul_a = k_q; mul_b = {2'b0, ee_q[65:33]}; end
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      B_IDLE: begin
        cur_q   <= q_item_i;
        sumsq_q <= '0;
      end
      B_SQ:    if (sq_q != 2'd0) sumsq_q <= sumsq_q + prod_q[65:0];
      B_SQRTW: if (sqrt_done) d_q <= root;
      B_DIVW:  if (div_done) quot_q <= quot;
      B_OV: begin
        seg_q     <= '1;
        seg_sat_q <= (qv[61:32] != '0);
      end
      B_OVSQ:  seg_q <= prod_q[63:0];
      B_K1: begin
        ee_q <= prod_q[65:0];
        k_q  <= {1'b0, quot_q[30:0], 3'b0} + {3'b0, quot_q[30:0], 1'b0};
      end
      B_K3:    big_q <= prod_q[67:0];
      B_K4: begin
        seg_sat_q <= (total[100:80] != '0);
        seg_q     <= (total[100:80] != '0) ? '1 : total[79:16];
      end
      B_UPD: begin
        px_q <= cur_q.x;
        py_q <= cur_q.y;
        pz_q <= cur_q.z;
        pr_q <= cur_q.radius;
      end
      default: ;
    endcase
    if (emit_fire) begin
      ocost_q <= sum_q;
      ocnt_q  <= cnt_q;
      osat_q  <= sat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      sq_q     <= '0;
      sum_q    <= '0;
      cnt_q    <= '0;
      sat_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sq_q    <= (state_q == B_SQ) ? sq_q + 1'b1 : 2'd0;
      if (state_q == B_ACC) begin
        sum_q <= s_sum[64] ? '1 : s_sum[63:0];
        sat_q <= sat_q | seg_sat_q | s_sum[64];
        if (cnt_q != '1) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (emit_fire) begin
        sum_q    <= '0;
        cnt_q    <= '0;
        sat_q    <= 1'b0;
        ovalid_q <= 1'b1;
      end else if (!out_stall_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = ovalid_q;
  assign strand_cost_o    = ocost_q;
  assign segment_count_o  = ocnt_q;
  assign cost_saturated_o = osat_q;

  a_sqrt_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_done |-> state_q == B_SQRTW) else $error("sqrt done outside wait");
  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == B_DIVW) else $error("divide done outside wait");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> state_q == B_IDLE && q_valid_i) else $error("pop while busy");
  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire |=> sum_q == '0 && cnt_q == '0 && !sat_q) else $error("sum not cleared");

endmodule

>>> src/strand_segment_cost_accumulator_core.sv
// Sums a per-segment cost over the control points of a strand and emits the total,
// the segment count and a saturation flag on the point marked last. A point that
// closes a segment runs a 33-step square root and a 62-step divider, each one bit
// per cycle, plus multiplies; a point with no segment skips them. A two-item queue
// lets input arrive while a segment is being worked on, and a result register lets
// work continue while the last result waits to be taken.
module strand_segment_cost_accumulator_core import sscacc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] point_x_i,
  input  logic [31:0] point_y_i,
  input  logic [31:0] point_z_i,
  input  logic [30:0] point_radius_i,
  input  logic [30:0] rest_length_i,
  input  logic        last_point_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] strand_cost_o,
  output logic [15:0] segment_count_o,
  output logic        cost_saturated_o
);

  logic  cost_mode_q;
  logic  q_valid, q_pop;
  item_t q_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cost_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      cost_mode_q <= cfg_wdata_i;
    end
  end

  sscacc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .point_z_i      (point_z_i),
    .point_radius_i (point_radius_i),
    .rest_length_i  (rest_length_i),
    .last_point_i   (last_point_i),
    .q_valid_o      (q_valid),
    .q_item_o       (q_item),
    .q_pop_i        (q_pop)
  );

  sscacc_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .mode_i           (cost_mode_q),
    .q_valid_i        (q_valid),
    .q_item_i         (q_item),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .strand_cost_o    (strand_cost_o),
    .segment_count_o  (segment_count_o),
    .cost_saturated_o (cost_saturated_o)
  );

endmodule
